@@ rtl/core/fmtp_pkg.sv @@
`default_nettype none

package fmtp_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;

   typedef enum logic [1:0] {
      KIND_FRACTION = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_ERROR    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_INDEX          = 2'd0,
      ERR_ROW_WIDTH      = 2'd1,
      ERR_LAST_ROW_WIDTH = 2'd2,
      ERR_ROW_COUNT      = 2'd3
   } err_type;

   typedef enum logic {
      REG_EXPECTED_ROWS = 1'b0,
      REG_EXPECTED_COLS = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       final_char;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [31:0] numerator;
      logic [31:0] denominator;
      logic [1:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   // limits in use, already clamped to the build maximums
   typedef struct packed {
      logic [8:0] rows;
      logic [8:0] cols;
   } lim_type;

   // up to two results per character, first slot goes out first
   typedef struct packed {
      logic    a_valid;
      rsp_type a;
      logic    b_valid;
      rsp_type b;
   } push_type;

   function automatic logic [31:0] mul10_add(input logic [31:0] acc, input logic [3:0] digit);
      mul10_add = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, digit};
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/fmtp_csr.sv @@
`default_nettype none

module fmtp_csr
   import fmtp_pkg::*;
#(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output lim_type          lim
);

   localparam logic [8:0] ROWS_CAP = (MAX_ROWS > 511) ? 9'h1FF : 9'(MAX_ROWS);
   localparam logic [8:0] COLS_CAP = (MAX_COLS > 511) ? 9'h1FF : 9'(MAX_COLS);

   logic [8:0]    rows_ff, rows_in;
   logic [8:0]    cols_ff, cols_in;
   logic          wr_en;
   reg_index_type idx;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      prdata  = '0;
      unique case (idx)
         REG_EXPECTED_ROWS: begin
            prdata = {23'd0, rows_ff};
            if (wr_en) rows_in = pwdata[8:0];
         end
         REG_EXPECTED_COLS: begin
            prdata = {23'd0, cols_ff};
            if (wr_en) cols_in = pwdata[8:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 9'd1;
         cols_ff <= 9'd1;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign lim.rows = (rows_ff < ROWS_CAP) ? rows_ff : ROWS_CAP;
   assign lim.cols = (cols_ff < COLS_CAP) ? cols_ff : COLS_CAP;

endmodule

`default_nettype wire

@@ rtl/core/fmtp_parse.sv @@
`default_nettype none

module fmtp_parse
   import fmtp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire req_type req_data,
   output logic         req_stall,
   input  wire lim_type lim,
   input  wire logic    queue_room,
   output push_type     push
);

   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff, in_data_in;

   logic [8:0]  row_ff, row_in;
   logic [8:0]  col_ff, col_in;
   logic [31:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic        reading_num_ff, reading_num_in;
   logic        digit_seen_ff, digit_seen_in;
   logic        discard_ff, discard_in;

   logic        process;
   logic        accept;
   logic [7:0]  ch;
   logic        fin;
   logic        is_digit;
   logic [3:0]  digit;
   logic [31:0] acc_next;
   logic        close;
   logic        err;
   logic [9:0]  parsed;

   assign process   = in_valid_ff && queue_room;
   assign req_stall = in_valid_ff && !queue_room;
   assign accept    = req_valid && !req_stall;

   assign ch       = in_data_ff.char_code;
   assign fin      = in_data_ff.final_char;
   assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   assign digit    = 4'(ch - CHAR_ZERO);
   assign acc_next = mul10_add(reading_num_ff ? num_ff : den_ff, digit);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      row_in         = row_ff;
      col_in         = col_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      reading_num_in = reading_num_ff;
      digit_seen_in  = digit_seen_ff;
      discard_in     = discard_ff;
      push           = '0;
      err            = 1'b0;
      close          = 1'b0;
      parsed         = '0;

      if (process && !discard_ff) begin
         if (is_digit) begin
            digit_seen_in = 1'b1;
            if (reading_num_ff) num_in = acc_next;
            else                den_in = acc_next;
         end else if (ch == CHAR_SLASH) begin
            reading_num_in = 1'b0;
         end

         close = (ch == CHAR_COMMA) || (ch == CHAR_SEMI) || fin;
         if (close) begin
            if (digit_seen_in) begin
               push.a_valid = 1'b1;
               if (row_ff >= lim.rows || col_ff >= lim.cols) begin
                  push.a.kind       = KIND_ERROR;
                  push.a.error_code = ERR_INDEX;
                  err               = 1'b1;
               end else begin
                  push.a.kind        = KIND_FRACTION;
                  push.a.row         = row_ff[7:0];
                  push.a.col         = col_ff[7:0];
                  push.a.numerator   = num_in;
                  push.a.denominator = reading_num_in ? 32'd1 : den_in;
                  col_in             = col_ff + 9'd1;
               end
            end
            num_in         = '0;
            den_in         = '0;
            reading_num_in = 1'b1;
            digit_seen_in  = 1'b0;
         end

         if (ch == CHAR_SEMI && !err) begin
            if (col_in != lim.cols) begin
               push.b_valid      = 1'b1;
               push.b.kind       = KIND_ERROR;
               push.b.error_code = ERR_ROW_WIDTH;
               err               = 1'b1;
            end else begin
               if (row_ff != 9'h1FF) row_in = row_ff + 9'd1;
               col_in = '0;
            end
         end

         if (fin && !err) begin
            parsed       = {1'b0, row_in} + {9'd0, col_in != 9'd0};
            push.b_valid = 1'b1;
            if (col_in != 9'd0 && col_in != lim.cols) begin
               push.b.kind       = KIND_ERROR;
               push.b.error_code = ERR_LAST_ROW_WIDTH;
            end else if (parsed != {1'b0, lim.rows}) begin
               push.b.kind       = KIND_ERROR;
               push.b.error_code = ERR_ROW_COUNT;
            end else begin
               push.b.kind = KIND_DONE;
            end
         end

         if (!fin && err) discard_in = 1'b1;

         push.a.last_of_run = !push.b_valid;
         push.b.last_of_run = 1'b1;
      end

      // end of text: return to the reset state for the next matrix
      if (process && fin) begin
         row_in         = '0;
         col_in         = '0;
         num_in         = '0;
         den_in         = '0;
         reading_num_in = 1'b1;
         digit_seen_in  = 1'b0;
         discard_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         row_ff         <= '0;
         col_ff         <= '0;
         num_ff         <= '0;
         den_ff         <= '0;
         reading_num_ff <= 1'b1;
         digit_seen_ff  <= 1'b0;
         discard_ff     <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         num_ff         <= num_in;
         den_ff         <= den_in;
         reading_num_ff <= reading_num_in;
         digit_seen_ff  <= digit_seen_in;
         discard_ff     <= discard_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/fmtp_rsp_queue.sv @@
`default_nettype none

module fmtp_rsp_queue
   import fmtp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          queue_room,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  wire logic     rsp_stall
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   rsp_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            pop;
   logic            wr_first;
   logic            wr_second;
   rsp_type         first;
   logic [PW-1:0]   wr_next;

   assign pop        = rsp_valid && !rsp_stall;
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = mem_ff[rd_ptr_ff];
   // room for a full pair of results
   assign queue_room = count_ff <= CW'(DEPTH - 2);

   assign wr_first  = push.a_valid || push.b_valid;
   assign wr_second = push.a_valid && push.b_valid;
   assign first     = push.a_valid ? push.a : push.b;
   assign wr_next   = wr_ptr_ff + PW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(wr_first) + PW'(wr_second);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + CW'(wr_first) + CW'(wr_second) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_first)  mem_ff[wr_ptr_ff] <= first;
      if (wr_second) mem_ff[wr_next]   <= push.b;
   end

endmodule

`default_nettype wire

@@ rtl/core/fraction_matrix_text_parser.sv @@
// A result passes through the input register, then the four-entry result queue,
// before it leaves.
// Throughput: one character per cycle while the result side keeps up; a
// character that closes an entry and ends the text, or a row of wrong width, can give two results.
// Reset (synchronous): parse state cleared, both size registers set to 1.
`default_nettype none

module fraction_matrix_text_parser
   import fmtp_pkg::*;
#(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire req_type     req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        rsp_stall,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   lim_type  lim;
   push_type push;
   logic     queue_room;

   fmtp_csr #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .lim    (lim)
   );

   fmtp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .lim       (lim),
      .queue_room(queue_room),
      .push      (push)
   );

   fmtp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .queue_room(queue_room),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire
